// ----- rtl/core/log_potential_accel_core_assert.svh -----
// ----------------------------------------------------------------------------
// log_potential_accel_core assertion macros
// Shared property forms for the block's checkers.
// ----------------------------------------------------------------------------
`ifndef LOG_POTENTIAL_ACCEL_CORE_ASSERT_SVH
`define LOG_POTENTIAL_ACCEL_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define LPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("log_potential_accel_core: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define LPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("log_potential_accel_core: next-cycle check failed");

`endif

// ----- rtl/core/lpa_pkg.sv -----
// ----------------------------------------------------------------------------
// lpa_pkg
// Types and constants shared by the logarithmic potential accelerator.
// ----------------------------------------------------------------------------
package lpa_pkg;

    // Saturation ceiling for all internal magnitudes (2^62 raw).
    localparam logic [62:0] CAP = 63'h4000_0000_0000_0000;
    // ln 2 with 30 fraction bits.
    localparam logic [31:0] LN2_Q30 = 32'd744261118;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = 2;

    typedef enum logic [2:0] {
        CFG_CORE_RADIUS  = 3'd0,
        CFG_AXIS_RATIO_Y = 3'd1,
        CFG_AXIS_RATIO_Z = 3'd2,
        CFG_VELOCITY_SQ  = 3'd3,
        CFG_MULTISTEP_ON = 3'd4,
        CFG_MIN_LEVEL    = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_APPLIED  = 2'd0,
        ST_SKIPPED  = 2'd1,
        ST_SINGULAR = 2'd2
    } t_status;

    typedef struct packed {
        logic [30:0] core_radius;
        logic [30:0] axis_ratio_y;
        logic [30:0] axis_ratio_z;
        logic [30:0] velocity_sq;
        logic        multistep_on;
        logic [3:0]  min_level;
    } t_cfg;

    typedef struct packed {
        logic [15:0] tag;
        logic [31:0] mag_x;
        logic [31:0] mag_y;
        logic [31:0] mag_z;
        logic        neg_x;
        logic        neg_y;
        logic        neg_z;
        logic        skip;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

    typedef enum logic [4:0] {
        SQ_IDLE,
        SQ_R2,
        SQ_X2,
        SQ_ADDX,
        SQ_DIVY,
        SQ_SQY,
        SQ_ADDY,
        SQ_DIVZ,
        SQ_SQZ,
        SQ_ADDZ,
        SQ_CHK,
        SQ_DAX,
        SQ_DIVAX,
        SQ_DAY,
        SQ_DIVAY0,
        SQ_DIVAY1,
        SQ_DIVAY2,
        SQ_DAZ,
        SQ_DIVAZ0,
        SQ_DIVAZ1,
        SQ_DIVAZ2,
        SQ_NORM,
        SQ_LSQ,
        SQ_LUPD,
        SQ_LN,
        SQ_POT,
        SQ_POTR,
        SQ_DONE
    } t_seq;

endpackage

// ----- rtl/core/lpa_div.sv -----
// ----------------------------------------------------------------------------
// lpa_div
// Bit-serial restoring divider, one quotient bit per cycle, saturating at CAP.
// ----------------------------------------------------------------------------
module lpa_div
    import lpa_pkg::*;
#(
    parameter int unsigned NUM_W = 79
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [62:0]       i_den,
    output logic              o_done,
    output logic [62:0]       o_quot
);

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [NUM_W-1:0]  r_num;
    logic [62:0]       r_den;
    logic [62:0]       r_rem;
    logic [63:0]       rem_sh;
    logic [63:0]       rem_nx;
    logic              ge;

    always_comb begin
        rem_sh = {r_rem, r_num[NUM_W-1]};
        ge     = rem_sh >= {1'b0, r_den};
        rem_nx = ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // numerator register doubles as the quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= rem_nx[62:0];
            r_num <= {r_num[NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = (|r_num[NUM_W-1:62]) ? CAP : {1'b0, r_num[61:0]};

endmodule

// ----- rtl/core/lpa_queue.sv -----
// ----------------------------------------------------------------------------
// lpa_queue
// Short FIFO of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module lpa_queue
    import lpa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_item    i_item,
    input  logic     i_pop,
    output t_item    o_head,
    output t_q_flags o_flags
);

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_PTR_W:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

    assign o_head        = r_mem[r_rd];
    assign o_flags.full  = r_cnt == (Q_PTR_W + 1)'(Q_DEPTH);
    assign o_flags.empty = r_cnt == '0;

endmodule

// ----- rtl/core/lpa_front.sv -----
// ----------------------------------------------------------------------------
// lpa_front
// Input side: take items, split sign and magnitude, decide level skipping.
// ----------------------------------------------------------------------------
module lpa_front
    import lpa_pkg::*;
#(
    parameter int unsigned LEVEL_COUNT = 16
) (
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_particle_tag,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [3:0]         i_step_level,
    input  t_cfg               i_cfg,
    input  t_q_flags           i_q_flags,
    output logic               o_push,
    output t_item              o_item
);

    localparam logic [6:0] LVL_MAX = 7'(LEVEL_COUNT - 1);

    logic [31:0] xu, yu, zu;
    logic [6:0]  lvl_in, lvl_min;

    always_comb begin
        xu      = i_pos_x;
        yu      = i_pos_y;
        zu      = i_pos_z;
        lvl_in  = (7'(i_step_level) > LVL_MAX) ? LVL_MAX : 7'(i_step_level);
        lvl_min = (7'(i_cfg.min_level) > LVL_MAX) ? LVL_MAX : 7'(i_cfg.min_level);

        o_item.tag   = i_particle_tag;
        o_item.neg_x = xu[31];
        o_item.neg_y = yu[31];
        o_item.neg_z = zu[31];
        o_item.mag_x = xu[31] ? (~xu + 32'd1) : xu;
        o_item.mag_y = yu[31] ? (~yu + 32'd1) : yu;
        o_item.mag_z = zu[31] ? (~zu + 32'd1) : zu;
        o_item.skip  = i_cfg.multistep_on && (lvl_in < lvl_min);
    end

    assign o_in_stall = i_q_flags.full;
    assign o_push     = i_in_valid && !i_q_flags.full;

endmodule

// ----- rtl/core/lpa_back.sv -----
// ----------------------------------------------------------------------------
// lpa_back
// Back end: sequencer over one multiplier and one serial divider, log unit,
// saturating output register.
// ----------------------------------------------------------------------------
module lpa_back
    import lpa_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_q_flags           i_q_flags,
    input  t_item              i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_result_tag,
    output logic signed [31:0] o_accel_x,
    output logic signed [31:0] o_accel_y,
    output logic signed [31:0] o_accel_z,
    output logic signed [31:0] o_potential,
    output logic [1:0]         o_status
);

    localparam int unsigned NW = 63 + FRAC_BITS;

    t_seq        r_state, n_state;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod_c;
    logic [63:0] r_prod;

    logic          div_start;
    logic [NW-1:0] div_num;
    logic [62:0]   div_den;
    logic          div_done;
    logic [62:0]   div_quot;

    t_item       r_item;
    t_status     r_status;
    logic [62:0] r_s;
    logic        r_sq_cap;
    logic [62:0] r_ax_mag, r_ay_mag, r_az_mag;
    logic [62:0] r_norm;
    logic [5:0]  r_k;
    logic [30:0] r_m;
    logic [29:0] r_frac;
    logic [4:0]  r_iter;
    logic        r_lneg;
    logic [38:0] r_pot;

    logic        r_out_valid;
    logic [15:0] r_out_tag;
    logic [31:0] r_out_ax, r_out_ay, r_out_az, r_out_pot;
    t_status     r_out_status;

    logic [30:0] bd, cd;
    logic [62:0] add_term, sum_sat;
    logic [63:0] sum_c;
    logic [31:0] sq_log;
    logic        k_ge;
    logic [6:0]  k_diff;
    logic [36:0] lmag;
    logic        load_out;
    logic        applied;

    function automatic logic [31:0] to_out(input logic [62:0] mag, input logic neg);
        logic big;
        big = |mag[62:31];
        if (neg) to_out = big ? 32'h8000_0000 : (32'd0 - mag[31:0]);
        else     to_out = big ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    lpa_div #(
        .NUM_W (NW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // shared datapath helpers
    always_comb begin
        bd       = (i_cfg.axis_ratio_y == '0) ? 31'd1 : i_cfg.axis_ratio_y;
        cd       = (i_cfg.axis_ratio_z == '0) ? 31'd1 : i_cfg.axis_ratio_z;
        prod_c   = mul_a * mul_b;
        add_term = (r_state == SQ_ADDX || !r_sq_cap) ? 63'(r_prod >> FRAC_BITS) : CAP;
        sum_c    = 64'(r_s) + 64'(add_term);
        sum_sat  = (sum_c > 64'(CAP)) ? CAP : sum_c[62:0];
        sq_log   = r_prod[61:30];
        k_ge     = r_k >= 6'(FRAC_BITS);
        k_diff   = k_ge ? (7'(r_k) - 7'(FRAC_BITS)) : (7'(FRAC_BITS) - 7'(r_k));
        lmag     = k_ge ? ({k_diff, 30'b0} + 37'(r_frac)) : ({k_diff, 30'b0} - 37'(r_frac));
        load_out = (r_state == SQ_DONE) && (!r_out_valid || !i_out_stall);
        applied  = r_status == ST_APPLIED;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SQ_IDLE:   if (!i_q_flags.empty) n_state = i_head.skip ? SQ_DONE : SQ_R2;
            SQ_R2:     n_state = SQ_X2;
            SQ_X2:     n_state = SQ_ADDX;
            SQ_ADDX:   n_state = SQ_DIVY;
            SQ_DIVY:   if (div_done) n_state = SQ_SQY;
            SQ_SQY:    n_state = SQ_ADDY;
            SQ_ADDY:   n_state = SQ_DIVZ;
            SQ_DIVZ:   if (div_done) n_state = SQ_SQZ;
            SQ_SQZ:    n_state = SQ_ADDZ;
            SQ_ADDZ:   n_state = SQ_CHK;
            SQ_CHK:    n_state = (r_s == '0) ? SQ_DONE : SQ_DAX;
            SQ_DAX:    n_state = SQ_DIVAX;
            SQ_DIVAX:  if (div_done) n_state = SQ_DAY;
            SQ_DAY:    n_state = SQ_DIVAY0;
            SQ_DIVAY0: if (div_done) n_state = SQ_DIVAY1;
            SQ_DIVAY1: if (div_done) n_state = SQ_DIVAY2;
            SQ_DIVAY2: if (div_done) n_state = SQ_DAZ;
            SQ_DAZ:    n_state = SQ_DIVAZ0;
            SQ_DIVAZ0: if (div_done) n_state = SQ_DIVAZ1;
            SQ_DIVAZ1: if (div_done) n_state = SQ_DIVAZ2;
            SQ_DIVAZ2: if (div_done) n_state = SQ_NORM;
            SQ_NORM:   if (r_norm[62]) n_state = SQ_LSQ;
            SQ_LSQ:    n_state = SQ_LUPD;
            SQ_LUPD:   n_state = (r_iter == '0) ? SQ_LN : SQ_LSQ;
            SQ_LN:     n_state = SQ_POT;
            SQ_POT:    n_state = SQ_POTR;
            SQ_POTR:   n_state = SQ_DONE;
            SQ_DONE:   if (load_out) n_state = SQ_IDLE;
            default:   n_state = SQ_IDLE;
        endcase
    end

    // unit controls per state
    always_comb begin
        o_pop     = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (r_state) inside
            SQ_IDLE: o_pop = !i_q_flags.empty;
            SQ_R2: begin
                mul_a = 32'(i_cfg.core_radius);
                mul_b = 32'(i_cfg.core_radius);
            end
            SQ_X2: begin
                mul_a = r_item.mag_x;
                mul_b = r_item.mag_x;
            end
            SQ_ADDX: begin
                div_start = 1'b1;
                div_num   = NW'(r_item.mag_y) << FRAC_BITS;
                div_den   = 63'(bd);
            end
            SQ_SQY, SQ_SQZ: begin
                mul_a = div_quot[31:0];
                mul_b = div_quot[31:0];
            end
            SQ_ADDY: begin
                div_start = 1'b1;
                div_num   = NW'(r_item.mag_z) << FRAC_BITS;
                div_den   = 63'(cd);
            end
            SQ_CHK: begin
                mul_a = 32'(i_cfg.velocity_sq);
                mul_b = r_item.mag_x;
            end
            SQ_DAX, SQ_DAY, SQ_DAZ: begin
                div_start = 1'b1;
                div_num   = NW'(r_prod);
                div_den   = r_s;
            end
            SQ_DIVAX: begin
                mul_a = 32'(i_cfg.velocity_sq);
                mul_b = r_item.mag_y;
            end
            SQ_DIVAY0, SQ_DIVAY1: begin
                div_start = div_done;
                div_num   = NW'(div_quot) << FRAC_BITS;
                div_den   = 63'(bd);
            end
            SQ_DIVAY2: begin
                mul_a = 32'(i_cfg.velocity_sq);
                mul_b = r_item.mag_z;
            end
            SQ_DIVAZ0, SQ_DIVAZ1: begin
                div_start = div_done;
                div_num   = NW'(div_quot) << FRAC_BITS;
                div_den   = 63'(cd);
            end
            SQ_LSQ: begin
                mul_a = 32'(r_m);
                mul_b = 32'(r_m);
            end
            SQ_LN: begin
                mul_a = 32'(lmag[36:6]);
                mul_b = LN2_Q30;
            end
            SQ_POT: begin
                mul_a = 32'(i_cfg.velocity_sq);
                mul_b = r_prod[61:30];
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SQ_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out)          r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod_c;
        unique case (r_state) inside
            SQ_IDLE: begin
                if (o_pop) begin
                    r_item   <= i_head;
                    r_status <= i_head.skip ? ST_SKIPPED : ST_APPLIED;
                end
            end
            SQ_X2:                  r_s <= 63'(r_prod >> FRAC_BITS);
            SQ_ADDX, SQ_ADDY, SQ_ADDZ: r_s <= sum_sat;
            SQ_SQY, SQ_SQZ:         r_sq_cap <= |div_quot[62:32];
            SQ_CHK:                 if (r_s == '0) r_status <= ST_SINGULAR;
            SQ_DIVAX:               if (div_done) r_ax_mag <= div_quot;
            SQ_DIVAY2:              if (div_done) r_ay_mag <= div_quot;
            SQ_DIVAZ2: begin
                if (div_done) begin
                    r_az_mag <= div_quot;
                    r_norm   <= r_s;
                    r_k      <= 6'd62;
                end
            end
            SQ_NORM: begin
                if (r_norm[62]) begin
                    r_m    <= r_norm[62:32];
                    r_iter <= 5'd29;
                end else begin
                    r_norm <= r_norm << 1;
                    r_k    <= r_k - 1'b1;
                end
            end
            SQ_LUPD: begin
                // square the mantissa, take one fraction bit per pass
                if (sq_log[31]) begin
                    r_m    <= sq_log[31:1];
                    r_frac <= {r_frac[28:0], 1'b1};
                end else begin
                    r_m    <= sq_log[30:0];
                    r_frac <= {r_frac[28:0], 1'b0};
                end
                r_iter <= r_iter - 1'b1;
            end
            SQ_LN:   r_lneg <= !k_ge;
            SQ_POTR: r_pot <= r_prod[63:25];
            default: r_sq_cap <= r_sq_cap;
        endcase

        if (load_out) begin
            r_out_tag    <= r_item.tag;
            r_out_status <= r_status;
            r_out_ax     <= applied ? to_out(r_ax_mag, !r_item.neg_x) : 32'd0;
            r_out_ay     <= applied ? to_out(r_ay_mag, !r_item.neg_y) : 32'd0;
            r_out_az     <= applied ? to_out(r_az_mag, !r_item.neg_z) : 32'd0;
            r_out_pot    <= applied ? to_out(63'(r_pot), r_lneg) : 32'd0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_result_tag = r_out_tag;
    assign o_accel_x    = signed'(r_out_ax);
    assign o_accel_y    = signed'(r_out_ay);
    assign o_accel_z    = signed'(r_out_az);
    assign o_potential  = signed'(r_out_pot);
    assign o_status     = r_out_status;

endmodule

// ----- rtl/core/log_potential_accel_core.sv -----
// ----------------------------------------------------------------------------
// log_potential_accel_core
// Logarithmic potential force and potential for one particle per item.
// ----------------------------------------------------------------------------
// Each item carries a tag, a signed Q16.16 position and a timestep level.
// The block forms s = R^2 + x^2 + (y/b)^2 + (z/c)^2 and returns saturated
// acceleration increments -v2*x/s, -v2*y/(s*b^2), -v2*z/(s*c^2) plus the
// potential 0.5*v2*ln(s), with status applied, skipped (level below the
// minimum with multistepping on) or singular (s of zero); the last two give
// zero values. A front end classifies items into a four-entry queue and
// keeps taking items while the back end works, until the queue is full;
// the back end handles one item at a time on a single bit-serial divider
// and one 32x32 multiplier. An applied item's time is set by the nine
// serial divisions over 63+FRAC_BITS numerator bits (79 at Q16.16) and by
// normalising s; a skipped item goes straight to the output and a singular
// one runs only the divisions of y and z. The result waits in an output
// register while the next item is already being computed. Configuration
// writes are always ready and must be issued only while the block is idle.
// ----------------------------------------------------------------------------
module log_potential_accel_core
    import lpa_pkg::*;
#(
    parameter int unsigned FRAC_BITS   = 16,
    parameter int unsigned LEVEL_COUNT = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item input
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_particle_tag,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [3:0]         i_step_level,
    // result output
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_result_tag,
    output logic signed [31:0] o_accel_x,
    output logic signed [31:0] o_accel_y,
    output logic signed [31:0] o_accel_z,
    output logic signed [31:0] o_potential,
    output logic [1:0]         o_status,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    // 1.0 in the block's fixed-point format
    localparam logic [30:0] ONE_FX = 31'(64'd1 << FRAC_BITS);

    t_cfg     r_cfg;
    t_q_flags q_flags;
    t_item    push_item;
    t_item    head_item;
    logic     push;
    logic     pop;

    // Register file: hold values until written; drop unknown indexes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.core_radius  <= ONE_FX;
            r_cfg.axis_ratio_y <= ONE_FX;
            r_cfg.axis_ratio_z <= ONE_FX;
            r_cfg.velocity_sq  <= ONE_FX;
            r_cfg.multistep_on <= 1'b0;
            r_cfg.min_level    <= 4'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CORE_RADIUS:  r_cfg.core_radius  <= i_cfg_data[30:0];
                CFG_AXIS_RATIO_Y: r_cfg.axis_ratio_y <= i_cfg_data[30:0];
                CFG_AXIS_RATIO_Z: r_cfg.axis_ratio_z <= i_cfg_data[30:0];
                CFG_VELOCITY_SQ:  r_cfg.velocity_sq  <= i_cfg_data[30:0];
                CFG_MULTISTEP_ON: r_cfg.multistep_on <= i_cfg_data[0];
                CFG_MIN_LEVEL:    r_cfg.min_level    <= i_cfg_data[3:0];
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Front: accept and classify, push into the queue.
    lpa_front #(
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_front (
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_particle_tag (i_particle_tag),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_step_level   (i_step_level),
        .i_cfg          (r_cfg),
        .i_q_flags      (q_flags),
        .o_push         (push),
        .o_item         (push_item)
    );

    lpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head_item),
        .o_flags (q_flags)
    );

    // Back: compute one item at a time, deliver through the output register.
    lpa_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_flags    (q_flags),
        .i_head       (head_item),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_result_tag (o_result_tag),
        .o_accel_x    (o_accel_x),
        .o_accel_y    (o_accel_y),
        .o_accel_z    (o_accel_z),
        .o_potential  (o_potential),
        .o_status     (o_status)
    );

endmodule

// ----- rtl/core/lpa_checker.sv -----
// ----------------------------------------------------------------------------
// lpa_checker
// Port-level checks on the result channel of log_potential_accel_core.
// ----------------------------------------------------------------------------
`include "log_potential_accel_core_assert.svh"

module lpa_checker
    import lpa_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_accel_x,
    input logic signed [31:0] o_accel_y,
    input logic signed [31:0] o_accel_z,
    input logic signed [31:0] o_potential,
    input logic [1:0]         o_status
);

    // a stalled result stays offered, with accel_x, potential and status unchanged
    `LPA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_accel_x) && $stable(o_potential) && $stable(o_status))

    // skipped and singular results carry no force
    `LPA_ASSERT_SAME(a_noforce_zero, i_clk, i_rst_n, o_out_valid && (o_status != ST_APPLIED), o_accel_x == 32'sd0 && o_accel_y == 32'sd0 && o_accel_z == 32'sd0)

    // skipped and singular results carry no potential
    `LPA_ASSERT_SAME(a_nopot_zero, i_clk, i_rst_n, o_out_valid && (o_status != ST_APPLIED), o_potential == 32'sd0)

endmodule

bind log_potential_accel_core lpa_checker u_lpa_checker (.*);

// ----- sim/tb_log_potential_accel_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_log_potential_accel_core
// Self-checking testbench for the logarithmic potential accelerator core.
// ----------------------------------------------------------------------------
// A queue of pending work (particle items, register writes and drain
// barriers) feeds a clocked driver that sends items in random bursts. A
// clocked monitor stalls the result channel on its own pattern and checks
// every result against a bit-exact predictor of the force, the potential
// and the status. Register writes happen only once all results are in.
// ----------------------------------------------------------------------------
module tb_log_potential_accel_core;
    import lpa_pkg::*;

    localparam int unsigned FRAC = 16;
    localparam logic [63:0] SAT_CAP = 64'h4000_0000_0000_0000;
    localparam logic [63:0] LN2_FX = 64'd744261118;
    localparam logic [2:0] CFG_UNUSED_IDX = 3'd6;
    localparam logic [2:0] CFG_UNUSED_TOP = 3'd7;

    typedef enum logic [1:0] {
        WK_ITEM,
        WK_CFG,
        WK_DRAIN
    } t_work_kind;

    typedef struct {
        t_work_kind  kind;
        logic [15:0] tag;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [3:0]  lvl;
        logic [2:0]  idx;
        logic [31:0] data;
    } t_work;

    typedef struct {
        logic [15:0] tag;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic [31:0] pot;
        logic [1:0]  status;
    } t_force;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [15:0]        i_particle_tag;
    logic signed [31:0] i_pos_x;
    logic signed [31:0] i_pos_y;
    logic signed [31:0] i_pos_z;
    logic [3:0]         i_step_level;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [15:0]        o_result_tag;
    logic signed [31:0] o_accel_x;
    logic signed [31:0] o_accel_y;
    logic signed [31:0] o_accel_z;
    logic signed [31:0] o_potential;
    logic [1:0]         o_status;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    log_potential_accel_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_particle_tag (i_particle_tag),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_step_level   (i_step_level),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_tag   (o_result_tag),
        .o_accel_x      (o_accel_x),
        .o_accel_y      (o_accel_y),
        .o_accel_z      (o_accel_z),
        .o_potential    (o_potential),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Testbench copy of the register file.
    logic [63:0] m_radius, m_ratio_y, m_ratio_z, m_vsq;
    logic        m_multistep;
    logic [3:0]  m_min_level;

    t_work  pending_work[$];
    t_force expected_forces[$];

    int unsigned mismatch_count = 0;
    int unsigned n_applied = 0, n_skipped = 0, n_singular = 0, n_cfg = 0;

    // ------------------------------------------------------------------------
    // Fixed-point helpers; all magnitudes, truncation toward zero.
    // ------------------------------------------------------------------------
    function automatic logic [63:0] fx_div(logic [63:0] n, logic [63:0] d);
        logic [63:0] q, r;
        q = n / d;
        r = n % d;
        if (q >= (SAT_CAP >> FRAC)) return SAT_CAP;
        return (q << FRAC) + ((r << FRAC) / d);
    endfunction

    function automatic logic [63:0] fx_sq(logic [63:0] t);
        logic [63:0] p;
        if (t >= 64'h1_0000_0000) return SAT_CAP;
        p = (t * t) >> FRAC;
        return (p > SAT_CAP) ? SAT_CAP : p;
    endfunction

    function automatic logic [63:0] sum_sat(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > SAT_CAP) ? SAT_CAP : s;
    endfunction

    // Apply the sign and clamp to the signed 32-bit range.
    function automatic logic [31:0] signed_sat(logic [63:0] mag, logic neg);
        if (neg) begin
            if (mag >= 64'h8000_0000) return 32'h8000_0000;
            return 32'(64'h1_0000_0000 - mag);
        end
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic logic [63:0] magnitude(logic [31:0] v);
        return v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
    endfunction

    // ------------------------------------------------------------------------
    // Force and potential for one particle under the current registers.
    // ------------------------------------------------------------------------
    function automatic t_force predict_force(t_work w);
        t_force      f;
        logic [63:0] mx, my, mz, s, t, bd, cd, m, frac, lmag, lnq, pot;
        logic        lneg;
        int          k;
        f.tag = w.tag;
        f.ax = '0; f.ay = '0; f.az = '0; f.pot = '0;
        // Level skip comes ahead of the singular check.
        if (m_multistep && (w.lvl < m_min_level)) begin
            f.status = ST_SKIPPED;
            return f;
        end
        mx = magnitude(w.px);
        my = magnitude(w.py);
        mz = magnitude(w.pz);
        // A zero axis ratio acts as one raw unit.
        bd = (m_ratio_y != 0) ? m_ratio_y : 64'd1;
        cd = (m_ratio_z != 0) ? m_ratio_z : 64'd1;
        s = (m_radius * m_radius) >> FRAC;
        s = sum_sat(s, (mx * mx) >> FRAC);
        s = sum_sat(s, fx_sq(fx_div(my, bd)));
        s = sum_sat(s, fx_sq(fx_div(mz, cd)));
        if (s == 0) begin
            f.status = ST_SINGULAR;
            return f;
        end
        f.ax = signed_sat((m_vsq * mx) / s, !w.px[31]);
        t = fx_div(fx_div((m_vsq * my) / s, bd), bd);
        f.ay = signed_sat(t, !w.py[31]);
        t = fx_div(fx_div((m_vsq * mz) / s, cd), cd);
        f.az = signed_sat(t, !w.pz[31]);
        // Normalize to a mantissa in [2^30, 2^31), then log by squaring.
        k = 0;
        for (int i = 62; i >= 0; i--) begin
            if (s[i]) begin
                k = i;
                break;
            end
        end
        m = (k >= 30) ? (s >> (k - 30)) : (s << (30 - k));
        frac = 0;
        for (int i = 29; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                frac[i] = 1'b1;
            end
        end
        if (k >= FRAC) begin
            lneg = 1'b0;
            lmag = (64'(k - FRAC) << 30) + frac;
        end else begin
            lneg = 1'b1;
            lmag = (64'(FRAC - k) << 30) - frac;
        end
        lnq = ((lmag >> 6) * LN2_FX) >> 30;
        pot = (m_vsq * lnq) >> 25;
        f.pot = signed_sat(pot, lneg);
        f.status = ST_APPLIED;
        return f;
    endfunction

    task automatic apply_register(logic [2:0] idx, logic [31:0] data);
        case (idx)
            CFG_CORE_RADIUS:  m_radius    = {33'd0, data[30:0]};
            CFG_AXIS_RATIO_Y: m_ratio_y   = {33'd0, data[30:0]};
            CFG_AXIS_RATIO_Z: m_ratio_z   = {33'd0, data[30:0]};
            CFG_VELOCITY_SQ:  m_vsq       = {33'd0, data[30:0]};
            CFG_MULTISTEP_ON: m_multistep = data[0];
            CFG_MIN_LEVEL:    m_min_level = data[3:0];
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want,
                                   logic [15:0] tag);
        $display("MISMATCH tag %0h %s: got %08h want %08h", tag, field, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Clock and the timeout guard.
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("Timeout with %0d results outstanding", expected_forces.size());
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: bursts of items with random gaps; register writes and drain
    // barriers wait until every expected result has been checked.
    // ------------------------------------------------------------------------
    int unsigned burst_left = 0, gap_left = 0, quiet_cycles = 0;

    always @(posedge i_clk) begin
        logic  in_fire, cfg_fire, hold, nv, ncv;
        t_work w;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            in_fire  = i_in_valid && !o_in_stall;
            cfg_fire = i_cfg_valid && o_cfg_ready;
            if (in_fire) begin
                expected_forces.push_back(predict_force(pending_work[0]));
                void'(pending_work.pop_front());
            end
            if (cfg_fire) begin
                apply_register(i_cfg_index, i_cfg_data);
                n_cfg++;
                void'(pending_work.pop_front());
            end
            quiet_cycles = (expected_forces.size() == 0 && !i_in_valid) ?
                           quiet_cycles + 1 : 0;
            // Hold a stalled payload until it is taken.
            hold = (i_in_valid && !in_fire) || (i_cfg_valid && !cfg_fire);
            if (!hold) begin
                nv  = 1'b0;
                ncv = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_work.size() > 0) begin
                    w = pending_work[0];
                    if (w.kind == WK_ITEM) begin
                        nv = 1'b1;
                        i_particle_tag <= w.tag;
                        i_pos_x        <= w.px;
                        i_pos_y        <= w.py;
                        i_pos_z        <= w.pz;
                        i_step_level   <= w.lvl;
                        if (burst_left > 0) begin
                            burst_left--;
                        end else begin
                            burst_left = $urandom_range(0, 12);
                            gap_left   = ($urandom_range(0, 2) == 0) ? 0 :
                                         $urandom_range(1, 40);
                        end
                    end else if (quiet_cycles >= 4) begin
                        if (w.kind == WK_CFG) begin
                            ncv = 1'b1;
                            i_cfg_index <= w.idx;
                            i_cfg_data  <= w.data;
                        end else begin
                            void'(pending_work.pop_front());
                        end
                    end
                end
                i_in_valid  <= nv;
                i_cfg_valid <= ncv;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: stall on a changing pattern and check every accepted result.
    // ------------------------------------------------------------------------
    int unsigned stall_mode = 0, mode_left = 0;

    always @(posedge i_clk) begin
        t_force f;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_forces.size() == 0) begin
                    $display("Unexpected result, tag %0h", o_result_tag);
                    mismatch_count++;
                end else begin
                    f = expected_forces.pop_front();
                    if (o_result_tag !== f.tag)
                        report_mismatch("tag", {16'd0, o_result_tag}, {16'd0, f.tag}, f.tag);
                    if (o_accel_x !== f.ax) report_mismatch("accel_x", o_accel_x, f.ax, f.tag);
                    if (o_accel_y !== f.ay) report_mismatch("accel_y", o_accel_y, f.ay, f.tag);
                    if (o_accel_z !== f.az) report_mismatch("accel_z", o_accel_z, f.az, f.tag);
                    if (o_potential !== f.pot)
                        report_mismatch("potential", o_potential, f.pot, f.tag);
                    if (o_status !== f.status)
                        report_mismatch("status", {30'd0, o_status}, {30'd0, f.status}, f.tag);
                    case (f.status)
                        ST_APPLIED: n_applied++;
                        ST_SKIPPED: n_skipped++;
                        default:    n_singular++;
                    endcase
                end
            end
            // Advance the stall pattern: none, light, or heavy.
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(20, 3000);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                default: i_out_stall <= ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus construction.
    // ------------------------------------------------------------------------
    int unsigned next_tag = 0;

    task automatic add_item(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [3:0] lvl);
        t_work w;
        w = '{kind: WK_ITEM, tag: 16'(next_tag), px: x, py: y, pz: z, lvl: lvl,
              idx: '0, data: '0};
        next_tag = next_tag + 1 + $urandom_range(0, 300);
        pending_work.push_back(w);
    endtask

    task automatic add_write(logic [2:0] idx, logic [31:0] data);
        t_work w;
        w = '{kind: WK_CFG, tag: '0, px: '0, py: '0, pz: '0, lvl: '0, idx: idx, data: data};
        pending_work.push_back(w);
    endtask

    task automatic add_drain();
        t_work w;
        w = '{kind: WK_DRAIN, tag: '0, px: '0, py: '0, pz: '0, lvl: '0, idx: '0, data: '0};
        pending_work.push_back(w);
    endtask

    // Register value biased toward the extremes; upper bit random garbage.
    function automatic logic [31:0] pick_reg();
        case ($urandom_range(0, 5))
            0:       return {$urandom_range(0, 1) == 1, 31'd0};
            1:       return 32'h7FFF_FFFF;
            2:       return 32'd1;
            3:       return 32'($urandom_range(16384, 262144));
            4:       return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Position spread over all magnitudes, with the full-scale ends now and then.
    function automatic logic [31:0] pick_pos();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom;
            default: return 32'($signed($urandom) >>> $urandom_range(0, 31));
        endcase
    endfunction

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_cfg_valid    = 1'b0;
        i_out_stall    = 1'b0;
        i_particle_tag = '0;
        i_pos_x        = '0;
        i_pos_y        = '0;
        i_pos_z        = '0;
        i_step_level   = '0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        m_radius    = 64'd65536;
        m_ratio_y   = 64'd65536;
        m_ratio_z   = 64'd65536;
        m_vsq       = 64'd65536;
        m_multistep = 1'b0;
        m_min_level = '0;

        // Directed: reset registers, origin and full-scale positions.
        add_item(32'd0, 32'd0, 32'd0, 4'd0);
        add_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 4'd15);
        add_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 4'd7);
        add_item(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 4'd3);
        // Near the singularity: no core radius and a tiny or zero position.
        add_drain();
        add_write(CFG_CORE_RADIUS, 32'd0);
        add_item(32'd0, 32'd0, 32'd0, 4'd0);
        add_item(32'd1, 32'hFFFF_FFFF, 32'd0, 4'd9);
        add_item(32'd0, 32'd0, 32'h0000_0100, 4'd2);
        // Level skipping at the top minimum level; skip beats singular.
        add_drain();
        add_write(CFG_MULTISTEP_ON, 32'd1);
        add_write(CFG_MIN_LEVEL, 32'd15);
        add_item(32'd0, 32'd0, 32'd0, 4'd0);
        add_item(32'h0010_0000, 32'd5, 32'd7, 4'd14);
        add_item(32'h0010_0000, 32'd5, 32'd7, 4'd15);
        // Zero axis ratios, unused register indexes, extreme radius and v2.
        add_drain();
        add_write(CFG_MIN_LEVEL, 32'd0);
        add_write(CFG_AXIS_RATIO_Y, 32'd0);
        add_write(CFG_AXIS_RATIO_Z, 32'h8000_0000);
        add_write(CFG_VELOCITY_SQ, 32'h7FFF_FFFF);
        add_write(CFG_CORE_RADIUS, 32'h7FFF_FFFF);
        add_write(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
        add_write(CFG_UNUSED_TOP, 32'h1234_5678);
        add_item(32'd1, 32'd1, 32'hFFFF_FFFF, 4'd1);
        add_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'd0);
        add_drain();
        add_write(CFG_CORE_RADIUS, 32'd1);
        add_write(CFG_VELOCITY_SQ, 32'd0);
        add_item(32'h0000_4000, 32'd3, 32'h8000_0000, 4'd5);
        add_item(32'd0, 32'd0, 32'd0, 4'd5);

        // Random phases: new register settings, then a stream of particles.
        for (int phase = 0; phase < 8; phase++) begin
            add_drain();
            add_write(CFG_CORE_RADIUS,  (phase == 0) ? 32'h0001_0000 : pick_reg());
            add_write(CFG_AXIS_RATIO_Y, pick_reg());
            add_write(CFG_AXIS_RATIO_Z, pick_reg());
            add_write(CFG_VELOCITY_SQ,  pick_reg());
            add_write(CFG_MULTISTEP_ON, $urandom);
            add_write(CFG_MIN_LEVEL,    $urandom);
            for (int n = 0; n < 72; n++) begin
                add_item(pick_pos(), pick_pos(), pick_pos(), 4'($urandom));
                // Pause now and then until the block has drained.
                if (n == 36 && phase[0]) add_drain();
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_work.size() != 0 || i_in_valid || i_cfg_valid) @(posedge i_clk);
        while (expected_forces.size() != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);

        $display("Checked %0d applied, %0d skipped, %0d singular results",
                 n_applied, n_skipped, n_singular);
        $display("across %0d register writes; %0d mismatches", n_cfg, mismatch_count);
        if (mismatch_count == 0 && expected_forces.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/lpa_pkg.sv
rtl/core/lpa_div.sv
rtl/core/lpa_queue.sv
rtl/core/lpa_front.sv
rtl/core/lpa_back.sv
rtl/core/log_potential_accel_core.sv
rtl/core/lpa_checker.sv
sim/tb_log_potential_accel_core.sv
